[design/saam_pkg.sv]
// shared types and constants for the sprite animate and move engine
package saam_pkg;

    // item operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_SET_POS = 2'd1,
        OP_SET_TGT = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_MOVE_SPEED     = 3'd0,
        CFG_FRAME_COUNT    = 3'd1,
        CFG_FRAME_INTERVAL = 3'd2,
        CFG_REPEAT_MODE    = 3'd3,
        CFG_FRAME_WIDTH    = 3'd4,
        CFG_FIRST_FRAME_X  = 3'd5
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_PREP = 6'b000100,
        S_DIV  = 6'b001000,
        S_STEP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned COORD_W = 16;
    localparam int unsigned SPEED_W = 12;
    localparam int unsigned DELTA_W = 16;
    localparam int unsigned ELAPSED_W = 32;
    localparam int unsigned FRAME_W = 8;

    localparam int unsigned MS_PER_S = 1000;
    // speed * delta
    localparam int unsigned PROD_W = SPEED_W + DELTA_W;
    // speed * delta * minor distance
    localparam int unsigned NUM_W = PROD_W + COORD_W;
    // 1000 * major distance fits in 26 bits
    localparam int unsigned DEN_W = 26;
    // every quotient stays below 2^19 (max speed*delta/1000 = 268365)
    localparam int unsigned QBITS = 19;
    localparam int unsigned CNT_W = $clog2(QBITS);

    // p / 1000 as ((p >> 3) * ceil(2^32 / 125)) >> 32, exact for p below 2^28
    localparam int unsigned PRE_SHIFT = 3;
    localparam int unsigned RECIP_W = 26;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned RECIP_PROD_W = PROD_W - PRE_SHIFT + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_125 = 26'd34359739;

    localparam logic [SPEED_W-1:0] SPEED_RST = 12'd100;
    localparam logic [FRAME_W-1:0] COUNT_RST = 8'd1;
    localparam logic [DELTA_W-1:0] INTERVAL_RST = 16'd100;

endpackage

[design/sprite_animate_and_move.sv]
// sprite engine: frame animation timer and stepped movement toward a target
// set position, set target and restart go from accept to S_DONE, then into the output register;
//   so does a tick with the sprite on target
// a tick that moves first runs S_MUL, S_PREP, S_DIV (skipped when both axes are equally far) and S_STEP:
//   the major step comes from a reciprocal multiply, one 19-step restoring divider
//   gives the minor step
// one item at a time; ready is low from accept until the result goes into the output register
// synchronous active-low reset loads the register defaults and clears position, target and timer
module sprite_animate_and_move (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_operation,
    input  logic [saam_pkg::DELTA_W-1:0]      i_delta_ms,
    input  logic signed [saam_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [saam_pkg::COORD_W-1:0] i_coord_y,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [saam_pkg::COORD_W-1:0] o_position_x,
    output logic signed [saam_pkg::COORD_W-1:0] o_position_y,
    output logic [saam_pkg::FRAME_W-1:0]      o_frame_index,
    output logic signed [saam_pkg::COORD_W-1:0] o_clip_x,
    output logic                              o_animation_done,
    output logic                              o_movement_done,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [saam_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [saam_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int unsigned CW = saam_pkg::COORD_W;
    localparam int unsigned QW = saam_pkg::QBITS;
    localparam int unsigned DW = saam_pkg::DEN_W;
    localparam int unsigned EW = saam_pkg::ELAPSED_W;
    localparam int unsigned FW = saam_pkg::FRAME_W;

    // configuration registers
    logic [saam_pkg::SPEED_W-1:0]  r_speed;
    logic [FW-1:0]                 r_count;
    logic [saam_pkg::DELTA_W-1:0]  r_interval;
    logic                          r_repeat;
    logic [11:0]                   r_frame_w;
    logic [11:0]                   r_first_x;

    // sprite state
    logic signed [CW-1:0] r_pos_x, r_pos_y, r_tgt_x, r_tgt_y;
    logic [EW-1:0]        r_elapsed;
    logic [FW-1:0]        r_frame;
    logic [CW-1:0]        r_clip;

    // sequencer and datapath
    saam_pkg::t_state              r_state;
    logic [saam_pkg::DELTA_W-1:0]  r_delta;
    logic [saam_pkg::PROD_W-1:0]   r_prod;
    logic [CW-1:0]                 r_dx, r_dy;
    logic [DW-1:0]                 r_div_den;
    logic [DW-1:0]                 r_rem;
    logic [QW-1:0]                 r_dq;
    logic [saam_pkg::CNT_W-1:0]    r_cnt;
    logic [QW-1:0]                 r_full;
    logic [QW-1:0]                 r_minor;
    logic                          r_adone, r_mdone;

    // output register
    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_px, r_out_py;
    logic [FW-1:0]        r_out_frame;
    logic [CW-1:0]        r_out_clip;
    logic                 r_out_adone, r_out_mdone;

    logic in_acc;
    logic out_load;

    // animation update evaluated in the accept cycle
    logic [EW:0]    e_sum;
    logic [EW-1:0]  e_sat;
    logic [FW:0]    next_frame;
    logic [EW-1:0]  n_elapsed;
    logic [FW-1:0]  n_frame;
    logic [CW-1:0]  n_clip;
    logic           n_adone;

    // major step by reciprocal multiply, minor numerator
    logic [saam_pkg::RECIP_PROD_W-1:0] recip_prod;
    logic [saam_pkg::NUM_W-1:0]        minor_num;

    // divider step
    logic [DW:0]    div_trial;
    logic           div_ge;
    logic [DW-1:0]  n_rem;
    logic [QW-1:0]  n_dq;

    // movement step
    logic [QW-1:0]        step_x, step_y;
    logic signed [CW-1:0] n_pos_x, n_pos_y;

    // move one axis toward its target, snapping to it when less than two steps remain
    function automatic logic signed [CW-1:0] step_axis(
        input logic signed [CW-1:0] cur,
        input logic signed [CW-1:0] fin,
        input logic [QW-1:0]        step
    );
        logic signed [CW:0] diff;
        logic [CW-1:0]      span;
        logic [QW-1:0]      span_w;
        logic [CW-1:0]      st;
        logic signed [CW-1:0] res;
        diff   = {fin[CW-1], fin} - {cur[CW-1], cur};
        span   = diff[CW] ? CW'(-diff) : diff[CW-1:0];
        span_w = QW'(span);
        st     = step[CW-1:0];
        res    = fin;
        // the step can only be taken when at least a full step remains afterwards
        if (span_w > step && (span_w - step) >= step) begin
            res = (cur < fin) ? cur + $signed(st) : cur - $signed(st);
        end
        return res;
    endfunction

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == saam_pkg::S_DONE) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == saam_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // frame timer, frame number and clip window for a tick
    always_comb begin
        e_sum      = {1'b0, r_elapsed} + (EW+1)'(i_delta_ms);
        e_sat      = e_sum[EW] ? {EW{1'b1}} : e_sum[EW-1:0];
        next_frame = {1'b0, r_frame} + (FW+1)'(1);
        n_elapsed  = r_elapsed;
        n_frame    = r_frame;
        n_clip     = r_clip;
        n_adone    = 1'b0;
        // a finished strip in stop mode freezes the timer
        if (r_repeat || r_frame < r_count) begin
            n_elapsed = e_sat;
            if (e_sat > EW'(r_interval)) begin
                n_elapsed = '0;
                if (next_frame >= {1'b0, r_count}) begin
                    if (r_repeat) begin
                        n_frame = '0;
                        n_clip  = CW'(r_first_x);
                    end else begin
                        n_frame = next_frame[FW-1:0];
                        n_adone = 1'b1;
                    end
                end else begin
                    n_frame = next_frame[FW-1:0];
                    n_clip  = r_clip + CW'(r_frame_w);
                end
            end
        end
    end

    // speed * delta / 1000 and speed * delta * minor distance
    always_comb begin
        recip_prod = r_prod[saam_pkg::PROD_W-1:saam_pkg::PRE_SHIFT] * saam_pkg::RECIP_125;
        minor_num  = r_prod * ((r_dx > r_dy) ? r_dy : r_dx);
    end

    // one restoring division step, one quotient bit per cycle
    always_comb begin
        div_trial = {r_rem, r_dq[QW-1]};
        div_ge    = div_trial >= {1'b0, r_div_den};
        n_rem     = div_ge ? DW'(div_trial - {1'b0, r_div_den}) : div_trial[DW-1:0];
        n_dq      = {r_dq[QW-2:0], div_ge};
    end

    // the axis with the larger distance takes the full step
    always_comb begin
        step_x  = (r_dy > r_dx) ? r_minor : r_full;
        step_y  = (r_dx > r_dy) ? r_minor : r_full;
        n_pos_x = step_axis(r_pos_x, r_tgt_x, step_x);
        n_pos_y = step_axis(r_pos_y, r_tgt_y, step_y);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= saam_pkg::SPEED_RST;
            r_count    <= saam_pkg::COUNT_RST;
            r_interval <= saam_pkg::INTERVAL_RST;
            r_repeat   <= 1'b1;
            r_frame_w  <= '0;
            r_first_x  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (saam_pkg::t_cfg_idx'(i_cfg_index))
                saam_pkg::CFG_MOVE_SPEED:     r_speed    <= i_cfg_data[saam_pkg::SPEED_W-1:0];
                saam_pkg::CFG_FRAME_COUNT:    r_count    <= i_cfg_data[FW-1:0];
                saam_pkg::CFG_FRAME_INTERVAL: r_interval <= i_cfg_data;
                saam_pkg::CFG_REPEAT_MODE:    r_repeat   <= i_cfg_data[0];
                saam_pkg::CFG_FRAME_WIDTH:    r_frame_w  <= i_cfg_data[11:0];
                saam_pkg::CFG_FIRST_FRAME_X:  r_first_x  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // sequencer and sprite state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= saam_pkg::S_IDLE;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_tgt_x   <= '0;
            r_tgt_y   <= '0;
            r_elapsed <= '0;
            r_frame   <= '0;
            r_clip    <= '0;
            r_adone   <= 1'b0;
            r_mdone   <= 1'b0;
        end else begin
            case (r_state)
                saam_pkg::S_IDLE: begin
                    if (in_acc) begin
                        r_adone <= 1'b0;
                        r_mdone <= 1'b0;
                        r_delta <= i_delta_ms;
                        r_state <= saam_pkg::S_DONE;
                        case (saam_pkg::t_op'(i_operation))
                            saam_pkg::OP_TICK: begin
                                r_elapsed <= n_elapsed;
                                r_frame   <= n_frame;
                                r_clip    <= n_clip;
                                r_adone   <= n_adone;
                                // only an off-target sprite needs the step datapath
                                if (r_pos_x != r_tgt_x || r_pos_y != r_tgt_y) begin
                                    r_state <= saam_pkg::S_MUL;
                                end
                            end
                            saam_pkg::OP_SET_POS: begin
                                r_pos_x <= i_coord_x;
                                r_pos_y <= i_coord_y;
                                r_tgt_x <= i_coord_x;
                                r_tgt_y <= i_coord_y;
                            end
                            saam_pkg::OP_SET_TGT: begin
                                r_tgt_x <= i_coord_x;
                                r_tgt_y <= i_coord_y;
                            end
                            saam_pkg::OP_RESTART: begin
                                r_elapsed <= '0;
                                r_frame   <= '0;
                                r_clip    <= CW'(r_first_x);
                            end
                            default: ;
                        endcase
                    end
                end
                saam_pkg::S_MUL: begin
                    r_prod  <= r_speed * r_delta;
                    r_dx    <= (r_pos_x > r_tgt_x) ? CW'(r_pos_x - r_tgt_x)
                                                   : CW'(r_tgt_x - r_pos_x);
                    r_dy    <= (r_pos_y > r_tgt_y) ? CW'(r_pos_y - r_tgt_y)
                                                   : CW'(r_tgt_y - r_pos_y);
                    r_state <= saam_pkg::S_PREP;
                end
                saam_pkg::S_PREP: begin
                    // major step: speed * delta / 1000
                    r_full    <= recip_prod[saam_pkg::RECIP_SHIFT +: QW];
                    // minor step divider load
                    r_rem     <= DW'(minor_num[saam_pkg::NUM_W-1:QW]);
                    r_dq      <= minor_num[QW-1:0];
                    r_div_den <= DW'(((r_dx > r_dy) ? r_dx : r_dy) * saam_pkg::MS_PER_S);
                    r_cnt     <= saam_pkg::CNT_W'(QW - 1);
                    // equal distances need no minor step
                    r_state   <= (r_dx == r_dy) ? saam_pkg::S_STEP : saam_pkg::S_DIV;
                end
                saam_pkg::S_DIV: begin
                    r_rem <= n_rem;
                    r_dq  <= n_dq;
                    r_cnt <= r_cnt - saam_pkg::CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_minor <= n_dq;
                        r_state <= saam_pkg::S_STEP;
                    end
                end
                saam_pkg::S_STEP: begin
                    r_pos_x <= n_pos_x;
                    r_pos_y <= n_pos_y;
                    r_mdone <= (n_pos_x == r_tgt_x) && (n_pos_y == r_tgt_y);
                    r_state <= saam_pkg::S_DONE;
                end
                saam_pkg::S_DONE: begin
                    if (out_load) begin
                        r_state <= saam_pkg::S_IDLE;
                    end
                end
                default: r_state <= saam_pkg::S_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_px    <= r_pos_x;
            r_out_py    <= r_pos_y;
            r_out_frame <= r_frame;
            r_out_clip  <= r_clip;
            r_out_adone <= r_adone;
            r_out_mdone <= r_mdone;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_position_x     = r_out_px;
    assign o_position_y     = r_out_py;
    assign o_frame_index    = r_out_frame;
    assign o_clip_x         = $signed(r_out_clip);
    assign o_animation_done = r_out_adone;
    assign o_movement_done  = r_out_mdone;

    // partial remainder never reaches the divisor, so 19 quotient bits suffice
    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == saam_pkg::S_DIV) |-> (r_rem < r_div_den))
        else $error("divider remainder out of range");

    // the minor axis step never exceeds the major one
    a_minor_le_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == saam_pkg::S_STEP && r_dx != r_dy) |-> (r_minor <= r_full))
        else $error("minor step larger than major step");

    // movement done means the sprite sits on its target
    a_move_on_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == saam_pkg::S_DONE && r_mdone) |->
        (r_pos_x == r_tgt_x && r_pos_y == r_tgt_y))
        else $error("movement done off target");

    // a finished strip always stops on a nonzero frame
    a_anim_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_animation_done) |-> (o_frame_index != '0))
        else $error("animation done on frame zero");

endmodule

[bench/testbench.sv]
// self-checking testbench for the sprite animate and move engine
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import saam_pkg::*;

    // frame-width register and first-frame register width
    localparam int unsigned SHEET_W = 12;
    // undefined register indexes, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    // percent of cycles each side idles
    localparam int unsigned IDLE_PCT = 19;
    // longest idle gap on the item side
    localparam int unsigned MAX_GAP = 50;
    // the slowest moving tick runs the divider, give it margin
    localparam int unsigned SETTLE_CYCLES = 60;
    // cycles with no word moving on any channel before giving up
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PHASES = 8;
    localparam int unsigned ITEMS_PER_PHASE = 200;
    // phase that runs with both sides never idling
    localparam int unsigned STEADY_PHASE = 3;

    // one result word as the block should present it
    typedef struct {
        logic signed [COORD_W-1:0] position_x;
        logic signed [COORD_W-1:0] position_y;
        logic [FRAME_W-1:0]        frame_index;
        logic signed [COORD_W-1:0] clip_x;
        logic                      animation_done;
        logic                      movement_done;
    } sprite_view_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    logic [1:0] i_operation;
    logic [DELTA_W-1:0] i_delta_ms;
    logic signed [COORD_W-1:0] i_coord_x;
    logic signed [COORD_W-1:0] i_coord_y;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [COORD_W-1:0] o_position_x;
    logic signed [COORD_W-1:0] o_position_y;
    logic [FRAME_W-1:0] o_frame_index;
    logic signed [COORD_W-1:0] o_clip_x;
    logic o_animation_done;
    logic o_movement_done;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // predicted register contents
    logic [SPEED_W-1:0] cfg_speed;
    logic [FRAME_W-1:0] cfg_count;
    logic [DELTA_W-1:0] cfg_interval;
    logic               cfg_repeat;
    logic [SHEET_W-1:0] cfg_frame_width;
    logic [SHEET_W-1:0] cfg_first_x;

    // predicted sprite state
    logic signed [COORD_W-1:0] cur_x, cur_y, aim_x, aim_y;
    logic [ELAPSED_W-1:0]      frame_timer;
    logic [FRAME_W-1:0]        frame_no;
    logic [COORD_W-1:0]        clip_pos;

    // words the block still owes, oldest first
    sprite_view_t expected_views[$];
    int unsigned mismatch_count;
    // no idling on either side while set
    logic steady;

    sprite_animate_and_move i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_delta_ms       (i_delta_ms),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_position_x     (o_position_x),
        .o_position_y     (o_position_y),
        .o_frame_index    (o_frame_index),
        .o_clip_x         (o_clip_x),
        .o_animation_done (o_animation_done),
        .o_movement_done  (o_movement_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // power-on register defaults and cleared sprite state
    task automatic reset_sprite();
        cfg_speed = SPEED_RST;
        cfg_count = COUNT_RST;
        cfg_interval = INTERVAL_RST;
        cfg_repeat = 1'b1;
        cfg_frame_width = '0;
        cfg_first_x = '0;
        cur_x = '0;
        cur_y = '0;
        aim_x = '0;
        aim_y = '0;
        frame_timer = '0;
        frame_no = '0;
        clip_pos = '0;
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MOVE_SPEED:     cfg_speed = data[SPEED_W-1:0];
            CFG_FRAME_COUNT:    cfg_count = data[FRAME_W-1:0];
            CFG_FRAME_INTERVAL: cfg_interval = data[DELTA_W-1:0];
            CFG_REPEAT_MODE:    cfg_repeat = data[0];
            CFG_FRAME_WIDTH:    cfg_frame_width = data[SHEET_W-1:0];
            CFG_FIRST_FRAME_X:  cfg_first_x = data[SHEET_W-1:0];
            default: ;
        endcase
    endtask

    // one axis: advance by stride toward goal, snap to goal when less than two strides away
    function automatic longint move_axis(input longint here, input longint goal,
                                         input longint stride);
        longint moved, gap;
        moved = goal;
        if (here < goal && goal - here > stride) moved = here + stride;
        else if (here > goal && here - goal > stride) moved = here - stride;
        gap = (moved > goal) ? moved - goal : goal - moved;
        return (gap < stride) ? goal : moved;
    endfunction

    // apply one item to the predicted state and build the word it yields
    task automatic advance_sprite(input t_op op, input logic [DELTA_W-1:0] delta,
                                  input logic signed [COORD_W-1:0] cx,
                                  input logic signed [COORD_W-1:0] cy,
                                  output sprite_view_t view);
        longint unsigned sum, prod;
        longint step_x, step_y, dist_x, dist_y;
        int unsigned nxt;
        view.animation_done = 1'b0;
        view.movement_done = 1'b0;
        case (op)
            OP_TICK: begin
                // frame timer runs while looping or until the strip ends
                if (cfg_repeat || frame_no < cfg_count) begin
                    sum = 64'(frame_timer) + 64'(delta);
                    frame_timer = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
                    if (frame_timer > 32'(cfg_interval)) begin
                        nxt = frame_no + 1;
                        frame_timer = '0;
                        if (nxt >= cfg_count) begin
                            if (cfg_repeat) begin
                                frame_no = '0;
                                clip_pos = COORD_W'(cfg_first_x);
                            end else begin
                                frame_no = nxt[FRAME_W-1:0];
                                view.animation_done = 1'b1;
                            end
                        end else begin
                            frame_no = nxt[FRAME_W-1:0];
                            clip_pos = clip_pos + COORD_W'(cfg_frame_width);
                        end
                    end
                end
                // movement: major axis gets the full step, minor axis a scaled one
                if (cur_x != aim_x || cur_y != aim_y) begin
                    prod = 64'(cfg_speed) * 64'(delta);
                    step_x = longint'(prod / MS_PER_S);
                    step_y = step_x;
                    dist_x = longint'(cur_x) - longint'(aim_x);
                    dist_y = longint'(cur_y) - longint'(aim_y);
                    if (dist_x < 0) dist_x = -dist_x;
                    if (dist_y < 0) dist_y = -dist_y;
                    if (dist_x > dist_y)
                        step_y = longint'((prod * 64'(dist_y)) /
                                          (64'(MS_PER_S) * 64'(dist_x)));
                    else if (dist_y > dist_x)
                        step_x = longint'((prod * 64'(dist_x)) /
                                          (64'(MS_PER_S) * 64'(dist_y)));
                    cur_x = COORD_W'(move_axis(cur_x, aim_x, step_x));
                    cur_y = COORD_W'(move_axis(cur_y, aim_y, step_y));
                    if (cur_x == aim_x && cur_y == aim_y) view.movement_done = 1'b1;
                end
            end
            OP_SET_POS: begin
                // target follows the position so nothing moves afterwards
                cur_x = cx;
                cur_y = cy;
                aim_x = cx;
                aim_y = cy;
            end
            OP_SET_TGT: begin
                aim_x = cx;
                aim_y = cy;
            end
            default: begin
                frame_timer = '0;
                frame_no = '0;
                clip_pos = COORD_W'(cfg_first_x);
            end
        endcase
        view.position_x = cur_x;
        view.position_y = cur_y;
        view.frame_index = frame_no;
        view.clip_x = clip_pos;
    endtask

    // drive one item, keep valid up until accepted, then predict its word
    task automatic send_item(input t_op op, input logic [DELTA_W-1:0] delta,
                             input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy);
        sprite_view_t view;
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            // gap of varying length so it lands on any phase of the block's work
            i_in_valid <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_delta_ms <= delta;
        i_coord_x <= cx;
        i_coord_y <= cy;
        do @(posedge i_clk); while (!o_in_ready);
        advance_sprite(op, delta, cx, cy, view);
        expected_views.push_back(view);
    endtask

    // register write; valid stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        load_register(idx, data);
    endtask

    // drop item valid, wait for every owed word, then let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // full register set after a junk write to a spare index, unused upper data bits carry junk
    task automatic apply_settings(input logic [SPEED_W-1:0] speed,
                                  input logic [FRAME_W-1:0] count,
                                  input logic [DELTA_W-1:0] interval,
                                  input logic rep,
                                  input logic [SHEET_W-1:0] fwidth,
                                  input logic [SHEET_W-1:0] first_x);
        settle();
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_MOVE_SPEED, {4'($urandom), speed});
        write_reg(CFG_FRAME_COUNT, {8'($urandom), count});
        write_reg(CFG_FRAME_INTERVAL, interval);
        write_reg(CFG_REPEAT_MODE, {15'($urandom), rep});
        write_reg(CFG_FRAME_WIDTH, {4'($urandom), fwidth});
        write_reg(CFG_FIRST_FRAME_X, {4'($urandom), first_x});
        i_cfg_valid <= 1'b0;
    endtask

    // mostly a point near the sprite, sometimes anywhere
    function automatic logic signed [COORD_W-1:0] pick_coord(
            input logic signed [COORD_W-1:0] around);
        int near;
        if ($urandom_range(99) < 30) return COORD_W'($urandom);
        near = int'(around) + int'($urandom_range(600)) - 300;
        if (near > 32767) near = 32767;
        if (near < -32768) near = -32768;
        return COORD_W'(near);
    endfunction

    // tick length: frame-rate sized mostly, plus full range and edge values
    function automatic logic [DELTA_W-1:0] pick_tick_delta();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return cfg_interval;
                    default: return cfg_interval + 1'b1;
                endcase
            end
            1, 2: return DELTA_W'($urandom);
            default: return DELTA_W'($urandom_range(300));
        endcase
    endfunction

    // default registers straight after reset, single-frame strip wraps on itself
    task automatic test_defaults_after_reset();
        send_item(OP_TICK, 16'd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'd101, 16'sd0, 16'sd0);
        send_item(OP_SET_TGT, 16'd0, 16'sd3, -16'sd4);
        send_item(OP_TICK, 16'd16, 16'sd0, 16'sd0);
        send_item(OP_RESTART, 16'hFFFF, -16'sd1, -16'sd1);
    endtask

    // one-shot strip to its end and freeze, then shrink the strip and loop
    task automatic test_strip_playback();
        apply_settings(12'd100, 8'd3, 16'd0, 1'b0, 12'hFFF, 12'hFFF);
        send_item(OP_RESTART, 16'd0, 16'sd0, 16'sd0);
        repeat (3) send_item(OP_TICK, 16'd1, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'hFFFF, 16'sd0, 16'sd0);
        // frame count now below the current frame
        apply_settings(12'd100, 8'd2, 16'd0, 1'b1, 12'hFFF, 12'hFFF);
        send_item(OP_TICK, 16'd1, 16'sd0, 16'sd0);
        // empty strip, looping then stopped
        apply_settings(12'd100, 8'd0, 16'd0, 1'b1, 12'd17, 12'd5);
        send_item(OP_TICK, 16'd1, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'd0, 16'sd0, 16'sd0);
        apply_settings(12'd100, 8'd0, 16'd0, 1'b0, 12'd17, 12'd5);
        send_item(OP_TICK, 16'd5, 16'sd0, 16'sd0);
    endtask

    // corner to corner diagonal, single-axis move, shallow slope
    task automatic test_movement_limits();
        apply_settings(12'hFFF, 8'd1, 16'hFFFF, 1'b1, 12'd0, 12'd0);
        send_item(OP_SET_POS, 16'd0, -16'sd32768, -16'sd32768);
        send_item(OP_SET_TGT, 16'd0, 16'sd32767, 16'sd32767);
        send_item(OP_TICK, 16'hFFFF, 16'sd0, 16'sd0);
        send_item(OP_SET_TGT, 16'd0, -16'sd32768, 16'sd32767);
        send_item(OP_TICK, 16'd1, 16'sd0, 16'sd0);
        send_item(OP_SET_POS, 16'd0, 16'sd0, 16'sd0);
        send_item(OP_SET_TGT, 16'd0, 16'sd1000, 16'sd10);
        send_item(OP_TICK, 16'd16, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'hFFFF, 16'sd0, 16'sd0);
    endtask

    // zero speed leaves both axes where they are
    task automatic test_zero_speed();
        apply_settings(12'd0, 8'd1, 16'd100, 1'b1, 12'd0, 12'd0);
        send_item(OP_SET_POS, 16'd0, 16'sd5, 16'sd0);
        send_item(OP_SET_TGT, 16'd0, 16'sd5, 16'sd7);
        send_item(OP_TICK, 16'hFFFF, 16'sd0, 16'sd0);
    endtask

    // random item mix under one register setting per phase
    task automatic test_random_traffic(input int unsigned phase);
        int unsigned pick;
        case (phase)
            0: apply_settings('0, '0, '0, 1'b0, '0, '0);
            1: apply_settings('1, '1, '1, 1'b1, '1, '1);
            default: apply_settings(
                $urandom_range(1) ? SPEED_W'($urandom_range(600, 1)) : SPEED_W'($urandom),
                ($urandom_range(9) < 8) ? FRAME_W'($urandom_range(8)) : FRAME_W'($urandom),
                ($urandom_range(9) < 7) ? DELTA_W'($urandom_range(300)) : DELTA_W'($urandom),
                1'($urandom), SHEET_W'($urandom), SHEET_W'($urandom));
        endcase
        steady = (phase == STEADY_PHASE);
        repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_item(OP_TICK, pick_tick_delta(), COORD_W'($urandom), COORD_W'($urandom));
            else if (pick < 78)
                send_item(OP_SET_TGT, DELTA_W'($urandom), pick_coord(cur_x), pick_coord(cur_y));
            else if (pick < 88)
                send_item(OP_SET_POS, DELTA_W'($urandom), pick_coord(cur_x), pick_coord(cur_y));
            else
                send_item(OP_RESTART, DELTA_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        end
        steady = 1'b0;
    endtask

    // result side: check each accepted word, then pick next cycle's ready
    always @(posedge i_clk) begin
        sprite_view_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_views.size() == 0) begin
                note_mismatch("result word with nothing outstanding");
            end else begin
                want = expected_views.pop_front();
                if (o_position_x !== want.position_x)
                    note_mismatch($sformatf("position_x got %0d want %0d",
                                            o_position_x, want.position_x));
                if (o_position_y !== want.position_y)
                    note_mismatch($sformatf("position_y got %0d want %0d",
                                            o_position_y, want.position_y));
                if (o_frame_index !== want.frame_index)
                    note_mismatch($sformatf("frame_index got %0d want %0d",
                                            o_frame_index, want.frame_index));
                if (o_clip_x !== want.clip_x)
                    note_mismatch($sformatf("clip_x got %0d want %0d",
                                            o_clip_x, want.clip_x));
                if (o_animation_done !== want.animation_done)
                    note_mismatch($sformatf("animation_done got %b want %b",
                                            o_animation_done, want.animation_done));
                if (o_movement_done !== want.movement_done)
                    note_mismatch($sformatf("movement_done got %b want %b",
                                            o_movement_done, want.movement_done));
            end
        end
        i_out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: any word moving on any channel resets the count
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_operation <= OP_TICK;
        i_delta_ms <= '0;
        i_coord_x <= '0;
        i_coord_y <= '0;
        i_out_ready <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MOVE_SPEED;
        i_cfg_data <= '0;
        steady = 1'b0;
        mismatch_count = 0;
        reset_sprite();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_defaults_after_reset();
        test_strip_playback();
        test_movement_limits();
        test_zero_speed();
        for (int unsigned phase = 0; phase < PHASES; phase++)
            test_random_traffic(phase);

        settle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/saam_pkg.sv
design/sprite_animate_and_move.sv
bench/testbench.sv
